// ===== hw/rtl/mrr_pkg.sv =====
// Package for the Miller-Rabin round core: payload structs, cause codes.
// No dependencies.
package mrr_pkg;

  typedef struct packed {
    logic [31:0] candidate;
    logic [31:0] witness;
  } mrr_in_t;

  typedef struct packed {
    logic       probably_prime;
    logic [2:0] cause;
  } mrr_out_t;

  localparam logic [2:0] CauseTrivial = 3'd0;
  localparam logic [2:0] CauseGcd     = 3'd1;
  localparam logic [2:0] CauseXHit    = 3'd2;
  localparam logic [2:0] CauseSqHit   = 3'd3;
  localparam logic [2:0] CauseFail    = 3'd4;

  // Work handed from the front end to the back end.
  typedef struct packed {
    logic        done;     // settled in front: result carried
    logic        pass;
    logic [2:0]  cause;
    logic [31:0] n;
    logic [31:0] a;
  } mrr_job_t;

endpackage

// ===== hw/rtl/mrr_front.sv =====
// Front end: accepts items and settles trivial candidates.
// Depends on mrr_pkg.
module mrr_front #(
  parameter int NumWidth = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  mrr_pkg::mrr_in_t  in_i,
  input  logic              push_i,
  output logic              full_o,
  output mrr_pkg::mrr_job_t job_o,
  output logic              job_valid_o,
  input  logic              job_ready_i
);
  import mrr_pkg::*;

  // Two-entry queue toward the back end.
  mrr_job_t   q_mem [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  mrr_job_t   j;
  logic [NumWidth-1:0] n, a;
  logic do_wr, do_rd;

  always_comb begin
    n = in_i.candidate[NumWidth-1:0];
    a = in_i.witness[NumWidth-1:0];
    j = '0;
    j.n = 32'(n);
    j.a = 32'(a);
    if (n < NumWidth'(2)) begin
      j.done = 1'b1;
    end else if (n == NumWidth'(2)) begin
      j.done = 1'b1; j.pass = 1'b1;
    end else if (!n[0]) begin
      j.done = 1'b1;
    end
    j.cause = CauseTrivial;
  end

  assign full_o      = (cnt_q == 2'd2);
  assign job_valid_o = (cnt_q != 2'd0);
  assign job_o       = q_mem[rd_q];
  assign do_wr       = push_i && !full_o;
  assign do_rd       = job_valid_o && job_ready_i;

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      q_mem[wr_q] <= j;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= 1'b0; rd_q <= 1'b0; cnt_q <= 2'd0;
    end else begin
      if (do_wr) wr_q <= ~wr_q;
      if (do_rd) rd_q <= ~rd_q;
      cnt_q <= cnt_q + 2'(do_wr) - 2'(do_rd);
    end
  end
endmodule

// ===== hw/rtl/mrr_modred.sv =====
// Shift-subtract remainder unit: r = p mod m, one quotient bit per cycle.
// Depends on mrr_pkg.
module mrr_modred #(
  parameter int NumWidth = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [2*NumWidth-1:0] p_i,
  input  logic [NumWidth-1:0]   m_i,
  output logic                  busy_o,
  output logic [NumWidth-1:0]   r_o
);
  import mrr_pkg::*;

  localparam int CntW = $clog2(2*NumWidth+1);

  logic [2*NumWidth-1:0] p_q;
  logic [NumWidth:0]     r_q;
  logic [NumWidth-1:0]   m_q;
  logic [CntW-1:0]       cnt_q;
  logic                  busy_q;
  logic [NumWidth+1:0]   t;

  always_comb begin
    t = {r_q, p_q[2*NumWidth-1]};
  end

  assign busy_o = busy_q;
  assign r_o    = r_q[NumWidth-1:0];

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      p_q <= p_i; m_q <= m_i; r_q <= '0;
    end else if (busy_q) begin
      p_q <= p_q << 1;
      if (t >= {2'b0, m_q}) r_q <= (NumWidth+1)'(t - {2'b0, m_q});
      else                  r_q <= (NumWidth+1)'(t);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; cnt_q <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1; cnt_q <= CntW'(2*NumWidth);
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) busy_q <= 1'b0;
    end
  end
endmodule

// ===== hw/rtl/mrr_back.sv =====
// Back end: gcd by remainders, then power and squarings mod n, one result reg.
// Depends on mrr_pkg, mrr_modred.
module mrr_back #(
  parameter int NumWidth = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  mrr_pkg::mrr_job_t job_i,
  input  logic              job_valid_i,
  output logic              job_ready_o,
  output mrr_pkg::mrr_out_t res_o,
  output logic              res_valid_o,
  input  logic              res_ready_i
);
  import mrr_pkg::*;

  localparam int BitW = $clog2(NumWidth);
  localparam logic [3:0] SIdle = 4'd0, SGcd = 4'd1, SGcdW = 4'd2, SSplit = 4'd3,
                         SBase = 4'd4, SBaseW = 4'd5, SSq = 4'd6, SSqW = 4'd7,
                         SMul = 4'd8, SMulW = 4'd9, SChk = 4'd10, SLoop = 4'd11,
                         SLoopW = 4'd12, SOut = 4'd13;

  logic [3:0]          st_q;
  logic [NumWidth-1:0] n_q, a_q, b_q, y_q, d_q, g_p_q, g_q_q;
  logic [BitW-1:0]     bit_q, s_q;
  logic                res_v_q;
  mrr_out_t            res_q, pend_q;
  logic                md_start, md_busy;
  logic [2*NumWidth-1:0] md_p;
  logic [NumWidth-1:0] md_r, md_m, nm1;
  logic [BitW-1:0]     top;

  assign nm1  = n_q - 1'b1;
  assign md_m = (st_q == SGcd) ? g_q_q : n_q;

  mrr_modred #(.NumWidth(NumWidth)) u_red (
    .clk_i, .rst_ni, .start_i(md_start), .p_i(md_p), .m_i(md_m),
    .busy_o(md_busy), .r_o(md_r)
  );

  always_comb begin
    md_start = 1'b0;
    md_p     = '0;
    case (st_q)
      SGcd:  begin md_start = 1'b1; md_p = (2*NumWidth)'(g_p_q); end
      SBase: begin md_start = 1'b1; md_p = (2*NumWidth)'(a_q); end
      SSq, SLoop: begin md_start = 1'b1; md_p = y_q * y_q; end
      SMul:  begin md_start = 1'b1; md_p = y_q * b_q; end
      default: ;
    endcase
  end

  // Highest set bit of d (d odd and nonzero).
  always_comb begin
    top = '0;
    for (int i = 0; i < NumWidth; i++) begin
      if (d_q[i]) top = BitW'(i);
    end
  end

  assign job_ready_o = (st_q == SIdle);
  assign res_valid_o = res_v_q;
  assign res_o       = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= SIdle; res_v_q <= 1'b0;
    end else begin
      // Verdict waits in pend_q until the output register is free.
      if (st_q == SOut && (!res_v_q || res_ready_i)) begin
        res_v_q <= 1'b1; res_q <= pend_q;
      end else if (res_v_q && res_ready_i) begin
        res_v_q <= 1'b0;
      end
      case (st_q)
        SIdle: if (job_valid_i) begin
          n_q <= job_i.n[NumWidth-1:0];
          a_q <= job_i.a[NumWidth-1:0];
          if (job_i.done) begin
            pend_q <= '{probably_prime: job_i.pass, cause: job_i.cause};
            st_q   <= SOut;
          end else begin
            g_p_q <= job_i.n[NumWidth-1:0];
            g_q_q <= job_i.a[NumWidth-1:0];
            st_q  <= SGcd;
          end
        end
        SGcd: begin
          if (g_q_q == '0) begin
            if (g_p_q > NumWidth'(1)) begin
              pend_q <= '{probably_prime: 1'b0, cause: CauseGcd};
              st_q   <= SOut;
            end else begin
              d_q <= nm1; s_q <= '0; st_q <= SSplit;
            end
          end else st_q <= SGcdW;
        end
        SGcdW: if (!md_busy) begin
          g_p_q <= g_q_q; g_q_q <= md_r; st_q <= SGcd;
        end
        SSplit: if (d_q[0]) st_q <= SBase;
                else begin d_q <= d_q >> 1; s_q <= s_q + 1'b1; end
        SBase: begin bit_q <= top; y_q <= NumWidth'(1); st_q <= SBaseW; end
        SBaseW: if (!md_busy) begin b_q <= md_r; st_q <= SSq; end
        SSq: st_q <= SSqW;
        SSqW: if (!md_busy) begin
          y_q <= md_r;
          st_q <= d_q[bit_q] ? SMul : SChk;
        end
        SMul: st_q <= SMulW;
        SMulW: if (!md_busy) begin y_q <= md_r; st_q <= SChk; end
        SChk: begin
          if (bit_q != '0) begin
            bit_q <= bit_q - 1'b1; st_q <= SSq;
          end else if (y_q == NumWidth'(1) || y_q == nm1) begin
            pend_q <= '{probably_prime: 1'b1, cause: CauseXHit}; st_q <= SOut;
          end else if (s_q <= BitW'(1)) begin
            pend_q <= '{probably_prime: 1'b0, cause: CauseFail}; st_q <= SOut;
          end else begin
            s_q <= s_q - 1'b1; st_q <= SLoop;
          end
        end
        SLoop: st_q <= SLoopW;
        SLoopW: if (!md_busy) begin
          y_q <= md_r;
          if (md_r == nm1) begin
            pend_q <= '{probably_prime: 1'b1, cause: CauseSqHit}; st_q <= SOut;
          end else if (s_q == BitW'(1)) begin
            pend_q <= '{probably_prime: 1'b0, cause: CauseFail}; st_q <= SOut;
          end else begin
            s_q <= s_q - 1'b1; st_q <= SLoop;
          end
        end
        SOut: if (!res_v_q || res_ready_i) st_q <= SIdle;
        default: st_q <= SIdle;
      endcase
    end
  end
endmodule

// ===== hw/rtl/miller_rabin_round_core.sv =====
// Top level of the Miller-Rabin round core: front end, and back end with its output reg.
// Depends on mrr_pkg, mrr_front, mrr_back.
//
//  channel | direction | handshake    | payload
//  input   | in        | push / full  | in_i  (candidate, witness)
//  result  | out       | empty / pop  | out_o (probably_prime, cause)
//
// Each modular reduction runs a start, one shift-subtract step per bit of the
// 2*NumWidth-bit product and a remainder pickup; one serves each gcd step, the
// base reduction, each square and each multiply, plus a check per exponent bit.
// The shift-subtract remainder unit performs these reductions.
// Trivial candidates are settled in the front and skip them. Reset empties the queue.
// A two-entry queue lets the front take items while the back works or
// its result waits on pop.
module miller_rabin_round_core #(
  parameter int NumWidth = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  mrr_pkg::mrr_in_t  in_i,
  input  logic              push,
  output logic              full,
  output mrr_pkg::mrr_out_t out_o,
  output logic              empty,
  input  logic              pop
);
  import mrr_pkg::*;

  mrr_job_t job;
  logic     job_valid, job_ready, res_valid;

  mrr_front #(.NumWidth(NumWidth)) u_front (
    .clk_i, .rst_ni, .in_i, .push_i(push), .full_o(full),
    .job_o(job), .job_valid_o(job_valid), .job_ready_i(job_ready)
  );

  mrr_back #(.NumWidth(NumWidth)) u_back (
    .clk_i, .rst_ni, .job_i(job), .job_valid_i(job_valid),
    .job_ready_o(job_ready), .res_o(out_o), .res_valid_o(res_valid),
    .res_ready_i(pop)
  );

  assign empty = !res_valid;

  a_cause_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (out_o.cause <= CauseFail)) else $error("cause out of range");
  a_pass_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && (out_o.cause == CauseGcd || out_o.cause == CauseFail))
      |-> !out_o.probably_prime) else $error("pass with failing cause");
  a_hit_pass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && (out_o.cause == CauseXHit || out_o.cause == CauseSqHit))
      |-> out_o.probably_prime) else $error("hit without pass");
endmodule
